// ===== hw/rtl/pte_pkg.sv =====
package pte_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [7:0] PRIO_MAX = 8'd5;
  localparam logic [7:0] PRIO_MIN = 8'd1;
  localparam logic [7:0] ID_FIRST = 8'd1;

  // Entry state codes
  localparam logic [1:0] ST_DEAD    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  typedef enum logic [1:0] {
    KIND_CREATE   = 2'd0,
    KIND_SET_PRIO = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_TOGGLE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2,
    RES_NO_MEMORY = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_WRITE,
    FSM_DONE
  } fsm_t;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
    logic [1:0] st;
  } entry_t;

  // Clamp a requested priority to PRIO_MIN..PRIO_MAX
  function automatic logic [7:0] clamp_prio(input logic [7:0] req);
    logic [7:0] res;
    if (req > PRIO_MAX) begin
      res = PRIO_MAX;
    end else if (req < PRIO_MIN) begin
      res = PRIO_MIN;
    end else begin
      res = req;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/pte_if.sv =====
// Request channel: one table operation per item
interface pte_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] target_id;
  logic [7:0] prio_value;
  logic       memory_refused;

  modport source (output valid, kind, target_id, prio_value, memory_refused, input ready);
  modport sink   (input valid, kind, target_id, prio_value, memory_refused, output ready);
endinterface

// Response channel: one result per request
interface pte_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] new_id;
  logic [1:0] entry_state;

  modport source (output valid, status, new_id, entry_state, input ready);
  modport sink   (input valid, status, new_id, entry_state, output ready);
endinterface

// ===== hw/rtl/pte_ram.sv =====
// Simple dual-port RAM, one write port, one read port with registered data
module pte_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/process_table_engine.sv =====
// Channel   Dir  Payload                                     Handshake
// in_req    in   kind, target_id, prio_value, memory_refused  valid/ready
// out_rsp   out  status, new_id, entry_state                  valid/ready
//
// One item at a time. A create on a full table or with memory refused skips
// the scan; other items scan the entry memory one entry per cycle through its
// single read port, and a scan ends at the first matching entry.
// Reset clears the valid bits and live count and sets the identifier counter to ID_FIRST.
// A result waits in the output register; a further result waits until taken.
module process_table_engine (
  input  logic      clk,
  input  logic      rst_n,
  pte_req_if.sink   in_req,
  pte_rsp_if.source out_rsp
);

  localparam logic [pte_pkg::IDX_W-1:0] LAST_IDX = pte_pkg::IDX_W'(pte_pkg::TABLE_ENTRIES - 1);
  localparam logic [pte_pkg::CNT_W-1:0] FULL_CNT = pte_pkg::CNT_W'(pte_pkg::TABLE_ENTRIES);

  pte_pkg::fsm_t state_r, state_nxt;

  logic [pte_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [pte_pkg::CNT_W-1:0]         live_count_r, live_count_nxt;
  logic [7:0]                        next_id_r, next_id_nxt;

  pte_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]     target_r, target_nxt;
  logic [7:0]     prio_r, prio_nxt;

  logic [pte_pkg::IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic                      scan_more_r, scan_more_nxt;
  logic [pte_pkg::IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic [pte_pkg::IDX_W-1:0] slot_r, slot_nxt;
  pte_pkg::entry_t           ent_r, ent_nxt;

  pte_pkg::res_t res_status_r, res_status_nxt;
  logic [7:0]    res_id_r, res_id_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  logic          out_valid_r, out_valid_nxt;
  pte_pkg::res_t out_status_r, out_status_nxt;
  logic [7:0]    out_id_r, out_id_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  logic                      ram_we;
  pte_pkg::entry_t           ram_wdata;
  pte_pkg::entry_t           ram_rdata;
  logic                      chk_live;
  logic                      chk_hit;

  pte_ram #(
    .WIDTH ($bits(pte_pkg::entry_t)),
    .DEPTH (pte_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (ram_wdata),
    .rd_addr (scan_addr_r),
    .rd_data (ram_rdata)
  );

  // Match test on the entry read back from memory
  always_comb begin
    chk_live = valid_r[chk_idx_r] && (ram_rdata.st != pte_pkg::ST_DEAD);
    if (kind_r == pte_pkg::KIND_CREATE) begin
      chk_hit = !chk_live;
    end else begin
      chk_hit = chk_live && (ram_rdata.id == target_r);
    end
  end

  assign in_req.ready        = (state_r == pte_pkg::FSM_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.new_id      = out_id_r;
  assign out_rsp.entry_state = out_st_r;

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    live_count_nxt = live_count_r;
    next_id_nxt    = next_id_r;
    kind_nxt       = kind_r;
    target_nxt     = target_r;
    prio_nxt       = prio_r;
    scan_addr_nxt  = scan_addr_r;
    scan_more_nxt  = scan_more_r;
    chk_idx_nxt    = scan_addr_r;
    chk_vld_nxt    = 1'b0;
    slot_nxt       = slot_r;
    ent_nxt        = ent_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_st_nxt     = out_st_r;
    ram_we         = 1'b0;
    ram_wdata      = ent_r;

    unique case (state_r)
      pte_pkg::FSM_IDLE: begin
        if (in_req.valid) begin
          kind_nxt       = pte_pkg::kind_t'(in_req.kind);
          target_nxt     = in_req.target_id;
          prio_nxt       = in_req.prio_value;
          res_status_nxt = pte_pkg::RES_OK;
          res_id_nxt     = 8'd0;
          res_st_nxt     = pte_pkg::ST_DEAD;
          scan_addr_nxt  = '0;
          scan_more_nxt  = 1'b1;
          // Refuse create early when full or without memory
          if (pte_pkg::kind_t'(in_req.kind) == pte_pkg::KIND_CREATE
              && live_count_r == FULL_CNT) begin
            res_status_nxt = pte_pkg::RES_FULL;
            state_nxt      = pte_pkg::FSM_DONE;
          end else if (pte_pkg::kind_t'(in_req.kind) == pte_pkg::KIND_CREATE
                       && in_req.memory_refused) begin
            res_status_nxt = pte_pkg::RES_NO_MEMORY;
            state_nxt      = pte_pkg::FSM_DONE;
          end else begin
            state_nxt = pte_pkg::FSM_SCAN;
          end
        end
      end

      pte_pkg::FSM_SCAN: begin
        // Issue the next read
        chk_vld_nxt = scan_more_r;
        if (scan_more_r) begin
          if (scan_addr_r == LAST_IDX) begin
            scan_more_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
        // Check the entry read last cycle
        if (chk_vld_r) begin
          if (chk_hit) begin
            slot_nxt    = chk_idx_r;
            ent_nxt     = ram_rdata;
            chk_vld_nxt = 1'b0;
            state_nxt   = pte_pkg::FSM_WRITE;
          end else if (chk_idx_r == LAST_IDX) begin
            res_status_nxt = (kind_r == pte_pkg::KIND_CREATE) ? pte_pkg::RES_FULL
                                                               : pte_pkg::RES_NOT_FOUND;
            chk_vld_nxt    = 1'b0;
            state_nxt      = pte_pkg::FSM_DONE;
          end
        end
      end

      pte_pkg::FSM_WRITE: begin
        // Modify the found entry and write it back; a query only reads its state
        unique case (kind_r)
          pte_pkg::KIND_CREATE: begin
            ram_we            = 1'b1;
            ram_wdata.id      = next_id_r;
            ram_wdata.prio    = prio_r;
            ram_wdata.st      = pte_pkg::ST_READY;
            valid_nxt[slot_r] = 1'b1;
            res_id_nxt        = next_id_r;
            next_id_nxt       = next_id_r + 8'd1;
            live_count_nxt    = live_count_r + 1'b1;
          end
          pte_pkg::KIND_SET_PRIO: begin
            ram_we         = 1'b1;
            ram_wdata.prio = pte_pkg::clamp_prio(prio_r);
          end
          pte_pkg::KIND_QUERY: begin
            res_st_nxt = ent_r.st;
          end
          pte_pkg::KIND_TOGGLE: begin
            ram_we       = 1'b1;
            ram_wdata.st = (ent_r.st == pte_pkg::ST_BLOCKED) ? pte_pkg::ST_READY
                                                             : pte_pkg::ST_BLOCKED;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
        state_nxt = pte_pkg::FSM_DONE;
      end

      pte_pkg::FSM_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_st_nxt     = res_st_r;
          state_nxt      = pte_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_nxt = pte_pkg::FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pte_pkg::FSM_IDLE;
      valid_r      <= '0;
      live_count_r <= '0;
      next_id_r    <= pte_pkg::ID_FIRST;
      scan_more_r  <= 1'b0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      live_count_r <= live_count_nxt;
      next_id_r    <= next_id_nxt;
      scan_more_r  <= scan_more_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    target_r     <= target_nxt;
    prio_r       <= prio_nxt;
    scan_addr_r  <= scan_addr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    slot_r       <= slot_nxt;
    ent_r        <= ent_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_st_r     <= res_st_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_st_r     <= out_st_nxt;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pte_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 1350;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] target_id;
    logic [7:0] prio_value;
    logic       memory_refused;
  } request_t;

  typedef struct packed {
    res_t       status;
    logic [7:0] new_id;
    logic [1:0] entry_state;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pte_req_if req_ch ();
  pte_rsp_if rsp_ch ();

  process_table_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // Shadow copy of the process table
  logic [7:0] tbl_id   [TABLE_ENTRIES];
  logic [7:0] tbl_prio [TABLE_ENTRIES];
  logic [1:0] tbl_st   [TABLE_ENTRIES];
  int         live_cnt = 0;
  logic [7:0] next_ident = ID_FIRST;

  request_t pending_q [$];
  outcome_t outcome_q [$];

  logic     req_fire = 1'b0;
  logic     rsp_fire = 1'b0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       req_wait = 0;
  int       req_calm = 0;
  int       rsp_wait = 0;
  int       rsp_calm = 0;
  int       rsp_taken = 0;
  int       hold_left = 0;
  request_t next_req;
  request_t seen_req;
  outcome_t want;

  always #6 clk = ~clk;

  // Wait length for one item: mostly uniform, with runs of back-to-back items
  function automatic int draw_wait(inout int calm_left);
    int n;
    n = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
    end else begin
      n = $urandom_range(0, 14);
    end
    return n;
  endfunction

  // Apply one request to the shadow table and return the answer it gives
  function automatic outcome_t table_outcome(request_t r);
    outcome_t o;
    int       slot;
    int       k;
    o.status      = RES_OK;
    o.new_id      = 8'd0;
    o.entry_state = ST_DEAD;
    slot = -1;
    if (r.kind == KIND_CREATE) begin
      if (live_cnt >= TABLE_ENTRIES) begin
        o.status = RES_FULL;
      end else if (r.memory_refused) begin
        o.status = RES_NO_MEMORY;
      end else begin
        for (k = 0; k < TABLE_ENTRIES; k++) begin
          if (slot < 0 && tbl_st[k] == ST_DEAD) slot = k;
        end
        if (slot < 0) begin
          o.status = RES_FULL;
        end else begin
          tbl_id[slot]   = next_ident;
          tbl_prio[slot] = r.prio_value;
          tbl_st[slot]   = ST_READY;
          o.new_id       = next_ident;
          next_ident     = next_ident + 8'd1;
          live_cnt++;
        end
      end
    end else begin
      // lowest live entry holding the identifier wins
      for (k = 0; k < TABLE_ENTRIES; k++) begin
        if (slot < 0 && tbl_st[k] != ST_DEAD && tbl_id[k] == r.target_id) slot = k;
      end
      if (slot < 0) begin
        o.status = RES_NOT_FOUND;
      end else if (r.kind == KIND_SET_PRIO) begin
        if (r.prio_value > PRIO_MAX) begin
          tbl_prio[slot] = PRIO_MAX;
        end else if (r.prio_value < PRIO_MIN) begin
          tbl_prio[slot] = PRIO_MIN;
        end else begin
          tbl_prio[slot] = r.prio_value;
        end
      end else if (r.kind == KIND_QUERY) begin
        o.entry_state = tbl_st[slot];
      end else begin
        tbl_st[slot] = (tbl_st[slot] == ST_BLOCKED) ? ST_READY : ST_BLOCKED;
      end
    end
    return o;
  endfunction

  task automatic add_req(kind_t kind, logic [7:0] target, logic [7:0] prio, logic refused);
    request_t r;
    r.kind           = kind;
    r.target_id      = target;
    r.prio_value     = prio;
    r.memory_refused = refused;
    pending_q.push_back(r);
  endtask

  // Driver: offer the next pending item after its drawn gap, hold until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_fire) req_wait = draw_wait(req_calm);
      if (req_wait > 0) begin
        req_wait--;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_req = pending_q.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= next_req.kind;
        req_ch.target_id      <= next_req.target_id;
        req_ch.prio_value     <= next_req.prio_value;
        req_ch.memory_refused <= next_req.memory_refused;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: draw a stall after each result; now and then hold off for a long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_fire) begin
        rsp_taken++;
        rsp_wait = draw_wait(rsp_calm);
        if (rsp_taken % 400 == 150) hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      req_fire <= 1'b0;
      rsp_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      rsp_fire <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        seen_req.kind           = kind_t'(req_ch.kind);
        seen_req.target_id      = req_ch.target_id;
        seen_req.prio_value     = req_ch.prio_value;
        seen_req.memory_refused = req_ch.memory_refused;
        outcome_q.push_back(table_outcome(seen_req));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: status %0d, new_id %0d, entry_state %0d",
                 rsp_ch.status, rsp_ch.new_id, rsp_ch.entry_state);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.new_id !== want.new_id) begin
            $error("new_id: expected %0d, got %0d", want.new_id, rsp_ch.new_id);
            mismatches++;
          end
          if (rsp_ch.entry_state !== want.entry_state) begin
            $error("entry_state: expected %0d, got %0d", want.entry_state,
                   rsp_ch.entry_state);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid          = 1'b0;
    req_ch.kind           = KIND_CREATE;
    req_ch.target_id      = 8'd0;
    req_ch.prio_value     = 8'd0;
    req_ch.memory_refused = 1'b0;
    rsp_ch.ready          = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tbl_id[k]   = 8'd0;
      tbl_prio[k] = 8'd0;
      tbl_st[k]   = ST_DEAD;
    end

    // Directed: lookups on an empty table, refused memory, clamping, toggling
    add_req(KIND_QUERY,    8'd0,   8'd0,   1'b0);
    add_req(KIND_TOGGLE,   8'd255, 8'd0,   1'b1);
    add_req(KIND_SET_PRIO, 8'd1,   8'd255, 1'b0);
    add_req(KIND_CREATE,   8'd0,   8'd0,   1'b1);
    add_req(KIND_CREATE,   8'd255, 8'd0,   1'b0);
    add_req(KIND_CREATE,   8'd0,   8'd255, 1'b0);
    add_req(KIND_SET_PRIO, 8'd1,   8'd0,   1'b0);
    add_req(KIND_SET_PRIO, 8'd1,   8'd255, 1'b0);
    add_req(KIND_SET_PRIO, 8'd2,   8'd1,   1'b0);
    add_req(KIND_SET_PRIO, 8'd2,   8'd5,   1'b0);
    add_req(KIND_SET_PRIO, 8'd2,   8'd6,   1'b1);
    add_req(KIND_QUERY,    8'd1,   8'd0,   1'b0);
    add_req(KIND_TOGGLE,   8'd1,   8'd0,   1'b0);
    add_req(KIND_QUERY,    8'd1,   8'd0,   1'b0);
    add_req(KIND_TOGGLE,   8'd1,   8'd0,   1'b0);
    add_req(KIND_QUERY,    8'd1,   8'd0,   1'b0);
    add_req(KIND_QUERY,    8'd3,   8'd0,   1'b0);
    add_req(KIND_TOGGLE,   8'd0,   8'd0,   1'b0);

    // Random: mostly identifiers that can be live, some anywhere in range
    for (int n = 0; n < RAND_ITEMS; n++) begin
      add_req(kind_t'($urandom_range(0, 3)),
              ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 17))
                                         : 8'($urandom_range(0, 255)),
              ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                          : 8'($urandom_range(0, 255)),
              $urandom_range(0, 2) == 0);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all items accepted, all results checked, then let the block settle
    while (pending_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
